/* src/rtd_pkg.sv */
`timescale 1ns / 1ps
package rtd_pkg;

    localparam int TEMP_FRAC_BITS = 8;

    localparam int CODE_W  = 15;
    localparam int CFG_W   = 16;
    localparam int TEMP_W  = 19;

    // resistance in Q16.16 and the two dividends
    localparam int RQ_W    = 32;
    localparam int P_W     = 60;
    localparam int DVD_W   = P_W + 16;
    localparam int SMALL_W = 40;

    localparam int DIV_STAGES  = DVD_W;
    localparam int SQ_W        = 64;
    localparam int SQRT_STAGES = 32;
    localparam int ROOT_W      = 32;

    // polynomial branch
    localparam int U_W        = 25;
    localparam int ACC_W      = 35;
    localparam int MAG_W      = ACC_W - 1;
    localparam int PROD_W     = MAG_W + U_W;
    localparam int POLY_Q     = 24;
    localparam int POLY_STEPS = 5;
    localparam int FIN_SH     = POLY_Q - TEMP_FRAC_BITS;
    localparam int TP_W       = ACC_W - FIN_SH + 1;

    // quadratic branch
    localparam int QM_W = 24 + TEMP_FRAC_BITS;
    localparam int QT_W = QM_W - 10;
    localparam logic [QT_W-1:0]  Q_RECIP  = QT_W'((64'd1 << QM_W) / 64'd1155);
    localparam logic [10:0]      Q_DIV    = 11'd1155;
    localparam logic [63:0]      HALF_DEN = 64'd37847040;

    localparam int QDLY = 2 * POLY_STEPS + 1 - 2;

    localparam logic [27:0] FOUR_ABS_B = 28'd231000000;
    localparam logic [62:0] DISC_LIMIT = 63'(64'd1758480889 << 32);
    localparam logic [ROOT_W-1:0] A_SCALED = 32'd2561343488;
    localparam logic [SMALL_W-1:0] U_MAX = SMALL_W'(64'd1 << POLY_Q);

    localparam logic signed [31:0] TEMP_MAX_I = 32'sd262143;
    localparam logic signed [31:0] TEMP_MIN_I = -32'sd131072;
    localparam logic [63:0]        TEMP_MAX_U = 64'd262143;

    localparam logic signed [ACC_W-1:0] POLY_C [POLY_STEPS+1] = '{
        -35'sd4060421816,
        35'sd4773426653,
        35'sd710806780,
        -35'sd169799780,
        -35'sd126924948,
        35'sd87869912
    };

    typedef enum logic [0:0] {
        CFG_NOMINAL   = 1'b0,
        CFG_REFERENCE = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [P_W-1:0]     prod_big;
        logic [SMALL_W-1:0] prod_small;
        logic [CFG_W-1:0]   r0;
    } rtd_job_t;

    typedef struct packed {
        logic           valid;
        logic           sat;
        logic [U_W-1:0] u;
    } rtd_side_t;

    typedef struct packed {
        logic            valid;
        logic            sat;
        logic            quad;
        logic [QT_W-1:0] tq;
    } rtd_quad_t;

endpackage

/* src/rtd_code_to_temperature.sv */
`timescale 1ns / 1ps
// done follows an accepted item through the front, the queue and the back
// throughput: one item per cycle, set by the fully pipelined divider,
//   square-root and Horner stages; busy stays low in normal use
// reset: rst_n async active low clears all valids, the queue and sets
//   the registers to nominal 100 ohms and reference 430 ohms
// results cannot be stalled: each is shown for one cycle with done
module rtd_code_to_temperature
    import rtd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [CODE_W-1:0]        rtd_code,
    input  logic                     cfg_write,
    input  logic [0:0]               cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    output logic                     done,
    output logic signed [TEMP_W-1:0] temperature,
    output logic                     saturated,
    output logic                     used_polynomial
);

    // configuration registers
    logic [CFG_W-1:0] nominal_reg;
    logic [CFG_W-1:0] reference_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nominal_reg   <= CFG_W'(100);
            reference_reg <= CFG_W'(430);
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_NOMINAL:   nominal_reg   <= cfg_data;
                CFG_REFERENCE: reference_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // front: capture the item, form resistance and the two dividends
    logic     accept;
    logic     front_valid;
    rtd_job_t front_job;
    logic     q_valid;
    rtd_job_t q_job;
    logic     q_full;

    assign accept = start && !busy;
    assign busy   = q_full;

    rtd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rtd_code  (rtd_code),
        .nominal   (nominal_reg),
        .reference (reference_reg),
        .job_valid (front_valid),
        .job       (front_job)
    );

    // two-entry queue between front and back
    rtd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_job  (front_job),
        .pop_valid (q_valid),
        .pop_job   (q_job),
        .full      (q_full)
    );

    // back: divide, square root, quadratic and polynomial, select and clip
    rtd_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .job_valid       (q_valid),
        .job             (q_job),
        .done            (done),
        .temperature     (temperature),
        .saturated       (saturated),
        .used_polynomial (used_polynomial)
    );

endmodule

/* src/rtd_front.sv */
`timescale 1ns / 1ps
module rtd_front
    import rtd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [CODE_W-1:0] rtd_code,
    input  logic [CFG_W-1:0]  nominal,
    input  logic [CFG_W-1:0]  reference,
    output logic              job_valid,
    output rtd_job_t          job
);

    logic              valid_reg;
    logic [RQ_W-1:0]   rq_reg;
    logic [CFG_W-1:0]  r0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= accept;
    end

    // zero nominal counts as one ohm
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rq_reg <= {31'(rtd_code) * 31'(reference), 1'b0};
            r0_reg <= (nominal == '0) ? CFG_W'(1) : nominal;
        end
    end

    always_comb
    begin
        job.prod_big   = P_W'(64'(rq_reg) * 64'(FOUR_ABS_B));
        job.prod_small = SMALL_W'(64'(rq_reg) * 64'd200);
        job.r0         = r0_reg;
    end

    assign job_valid = valid_reg;

endmodule

/* src/rtd_queue.sv */
`timescale 1ns / 1ps
module rtd_queue
    import rtd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  rtd_job_t push_job,
    output logic     pop_valid,
    output rtd_job_t pop_job,
    output logic     full
);

    rtd_job_t    mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        do_push;
    logic        do_pop;

    // back end never stalls, so the head leaves every cycle it is there
    assign do_pop  = (count_reg != 2'd0);
    assign do_push = push && !full;
    assign full    = (count_reg == 2'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    assign pop_valid = do_pop;
    assign pop_job   = mem_reg[rd_ptr_reg];

endmodule

/* src/rtd_div.sv */
`timescale 1ns / 1ps
module rtd_div
    import rtd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [DVD_W-1:0]   dividend_big,
    input  logic [SMALL_W-1:0] dividend_small,
    input  logic [CFG_W-1:0]   divisor,
    output logic               out_valid,
    output logic [DVD_W-1:0]   quotient_big,
    output logic [SMALL_W-1:0] quotient_small
);

    logic               valid_reg [DIV_STAGES];
    logic [CFG_W-1:0]   dsr_reg   [DIV_STAGES];
    logic [CFG_W-1:0]   remb_reg  [DIV_STAGES];
    logic [CFG_W-1:0]   rems_reg  [DIV_STAGES];
    logic [DVD_W-1:0]   shb_reg   [DIV_STAGES];
    logic [SMALL_W-1:0] shs_reg   [DIV_STAGES];

    // one restoring step per stage, two lanes sharing the divisor
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        logic               vin;
        logic [CFG_W-1:0]   din;
        logic [CFG_W-1:0]   rbin;
        logic [CFG_W-1:0]   rsin;
        logic [DVD_W-1:0]   sbin;
        logic [SMALL_W-1:0] ssin;
        logic [CFG_W:0]     trial_b;
        logic [CFG_W:0]     trial_s;
        logic [CFG_W-1:0]   remb_next;
        logic [CFG_W-1:0]   rems_next;
        logic [DVD_W-1:0]   shb_next;
        logic [SMALL_W-1:0] shs_next;

        if (g == 0) begin : g_head
            assign vin  = in_valid;
            assign din  = divisor;
            assign rbin = '0;
            assign rsin = '0;
            assign sbin = dividend_big;
            assign ssin = dividend_small;
        end else begin : g_body
            assign vin  = valid_reg[g-1];
            assign din  = dsr_reg[g-1];
            assign rbin = remb_reg[g-1];
            assign rsin = rems_reg[g-1];
            assign sbin = shb_reg[g-1];
            assign ssin = shs_reg[g-1];
        end

        always_comb
        begin
            trial_b = {rbin, sbin[DVD_W-1]};
            if (trial_b >= {1'b0, din})
            begin
                remb_next = CFG_W'(trial_b - {1'b0, din});
                shb_next  = {sbin[DVD_W-2:0], 1'b1};
            end
            else
            begin
                remb_next = trial_b[CFG_W-1:0];
                shb_next  = {sbin[DVD_W-2:0], 1'b0};
            end

            // short lane only needs the last stages
            trial_s = {rsin, ssin[SMALL_W-1]};
            if (g < DVD_W - SMALL_W)
            begin
                rems_next = rsin;
                shs_next  = ssin;
            end
            else if (trial_s >= {1'b0, din})
            begin
                rems_next = CFG_W'(trial_s - {1'b0, din});
                shs_next  = {ssin[SMALL_W-2:0], 1'b1};
            end
            else
            begin
                rems_next = trial_s[CFG_W-1:0];
                shs_next  = {ssin[SMALL_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[g] <= 1'b0;
            else
                valid_reg[g] <= vin;
        end

        always_ff @(posedge clk)
        begin
            dsr_reg[g]  <= din;
            remb_reg[g] <= remb_next;
            rems_reg[g] <= rems_next;
            shb_reg[g]  <= shb_next;
            shs_reg[g]  <= shs_next;
        end
    end

    assign out_valid      = valid_reg[DIV_STAGES-1];
    assign quotient_big   = shb_reg[DIV_STAGES-1];
    assign quotient_small = shs_reg[DIV_STAGES-1];

endmodule

/* src/rtd_sqrt.sv */
`timescale 1ns / 1ps
module rtd_sqrt
    import rtd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  rtd_side_t         in_side,
    input  logic [SQ_W-1:0]   radicand,
    output rtd_side_t         out_side,
    output logic [ROOT_W-1:0] root
);

    rtd_side_t       side_reg [SQRT_STAGES];
    logic [SQ_W-1:0] v_reg    [SQRT_STAGES];
    logic [SQ_W-1:0] r_reg    [SQRT_STAGES];

    // one result bit per stage, floor root
    for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
        localparam logic [SQ_W-1:0] STEP_BIT = SQ_W'(64'd1 << (SQ_W - 2 - 2 * g));
        rtd_side_t       sin;
        logic [SQ_W-1:0] vin;
        logic [SQ_W-1:0] rin;
        logic [SQ_W-1:0] sum;
        logic [SQ_W-1:0] v_next;
        logic [SQ_W-1:0] r_next;

        if (g == 0) begin : g_head
            assign sin = in_side;
            assign vin = radicand;
            assign rin = '0;
        end else begin : g_body
            assign sin = side_reg[g-1];
            assign vin = v_reg[g-1];
            assign rin = r_reg[g-1];
        end

        always_comb
        begin
            sum = rin + STEP_BIT;
            if (vin >= sum)
            begin
                v_next = vin - sum;
                r_next = (rin >> 1) + STEP_BIT;
            end
            else
            begin
                v_next = vin;
                r_next = rin >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                side_reg[g] <= '0;
            else
                side_reg[g] <= sin;
        end

        always_ff @(posedge clk)
        begin
            v_reg[g] <= v_next;
            r_reg[g] <= r_next;
        end
    end

    assign out_side = side_reg[SQRT_STAGES-1];
    assign root     = r_reg[SQRT_STAGES-1][ROOT_W-1:0];

endmodule

/* src/rtd_back.sv */
`timescale 1ns / 1ps
module rtd_back
    import rtd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     job_valid,
    input  rtd_job_t                 job,
    output logic                     done,
    output logic signed [TEMP_W-1:0] temperature,
    output logic                     saturated,
    output logic                     used_polynomial
);

    logic               div_valid;
    logic [DVD_W-1:0]   term;
    logic [SMALL_W-1:0] u_raw;

    rtd_side_t          prep_side_reg;
    logic [SQ_W-1:0]    prep_rad_reg;
    rtd_side_t          prep_side_next;
    logic [SQ_W-1:0]    prep_rad_next;

    rtd_side_t          sq_side;
    logic [ROOT_W-1:0]  sq_root;

    rtd_div u_div (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (job_valid),
        .dividend_big   ({job.prod_big, 16'd0}),
        .dividend_small (job.prod_small),
        .divisor        (job.r0),
        .out_valid      (div_valid),
        .quotient_big   (term),
        .quotient_small (u_raw)
    );

    // discriminant and clamped polynomial argument
    always_comb
    begin
        prep_side_next.valid = div_valid;
        prep_side_next.sat   = (term > DVD_W'(DISC_LIMIT));
        prep_side_next.u     = (u_raw > U_MAX) ? U_MAX[U_W-1:0] : u_raw[U_W-1:0];
        prep_rad_next        = prep_side_next.sat ? '0
                               : {1'b0, DISC_LIMIT - term[SQ_W-2:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prep_side_reg <= '0;
        else
            prep_side_reg <= prep_side_next;
    end

    always_ff @(posedge clk)
    begin
        prep_rad_reg <= prep_rad_next;
    end

    rtd_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_side  (prep_side_reg),
        .radicand (prep_rad_reg),
        .out_side (sq_side),
        .root     (sq_root)
    );

    // quadratic branch: (A - sqrt) scaled, then divide by 1155
    logic              qa_valid_reg, qa_sat_reg, qa_quad_reg;
    logic [QM_W-1:0]   qa_m_reg;
    logic              qb_valid_reg, qb_sat_reg, qb_quad_reg;
    logic [QM_W-1:0]   qb_m_reg;
    logic [QT_W-1:0]   qb_q0_reg;
    rtd_quad_t         qc_next;
    rtd_quad_t         qd_reg [QDLY];
    logic [ROOT_W-1:0] qn;
    logic [63:0]       qscaled;
    logic [QM_W+QT_W-1:0] qprod;
    logic [QM_W:0]     qrem;

    always_comb
    begin
        qn      = A_SCALED - sq_root;
        qscaled = ((64'(qn) * 64'd100) << TEMP_FRAC_BITS) + HALF_DEN;
        qprod   = (QM_W+QT_W)'(qa_m_reg) * (QM_W+QT_W)'(Q_RECIP);
        qrem    = {1'b0, qb_m_reg} - ((QM_W+1)'(qb_q0_reg) * (QM_W+1)'(Q_DIV));
        qc_next.valid = qb_valid_reg;
        qc_next.sat   = qb_sat_reg;
        qc_next.quad  = qb_quad_reg;
        qc_next.tq    = qb_q0_reg + QT_W'(qrem >= (QM_W+1)'(Q_DIV));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qa_valid_reg <= 1'b0;
            qb_valid_reg <= 1'b0;
        end
        else
        begin
            qa_valid_reg <= sq_side.valid;
            qb_valid_reg <= qa_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        qa_sat_reg  <= sq_side.sat;
        qa_quad_reg <= (sq_root <= A_SCALED);
        qa_m_reg    <= QM_W'(qscaled >> 16);
        qb_sat_reg  <= qa_sat_reg;
        qb_quad_reg <= qa_quad_reg;
        qb_m_reg    <= qa_m_reg;
        qb_q0_reg   <= QT_W'(qprod >> QM_W);
    end

    for (genvar g = 0; g < QDLY; g++) begin : g_qdly
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                qd_reg[g] <= '0;
            else if (g == 0)
                qd_reg[g] <= qc_next;
            else
                qd_reg[g] <= qd_reg[g-1];
        end
    end

    // polynomial branch: Horner, multiply stage then round-and-add stage
    logic [PROD_W-1:0]        prod_reg [POLY_STEPS];
    logic                     psgn_reg [POLY_STEPS];
    logic [U_W-1:0]           mu_reg   [POLY_STEPS];
    logic signed [ACC_W-1:0]  acc_reg  [POLY_STEPS];
    logic [U_W-1:0]           ua_reg   [POLY_STEPS];
    logic signed [TP_W-1:0]   tp_reg;

    for (genvar g = 0; g < POLY_STEPS; g++) begin : g_horner
        logic signed [ACC_W-1:0] ain;
        logic [U_W-1:0]          uin;
        logic [ACC_W-1:0]        amag;
        logic [ACC_W-1:0]        rnd;
        logic signed [ACC_W-1:0] sv;

        if (g == 0) begin : g_head
            assign ain = POLY_C[POLY_STEPS];
            assign uin = sq_side.u;
        end else begin : g_body
            assign ain = acc_reg[g-1];
            assign uin = ua_reg[g-1];
        end

        always_comb
        begin
            amag = ain[ACC_W-1] ? ACC_W'(-ain) : ACC_W'(ain);
            rnd  = ACC_W'((prod_reg[g] + PROD_W'(64'd1 << (POLY_Q - 1))) >> POLY_Q);
            sv   = psgn_reg[g] ? -$signed(rnd) : $signed(rnd);
        end

        always_ff @(posedge clk)
        begin
            prod_reg[g] <= PROD_W'(amag[MAG_W-1:0]) * PROD_W'(uin);
            psgn_reg[g] <= ain[ACC_W-1];
            mu_reg[g]   <= uin;
            acc_reg[g]  <= sv + POLY_C[POLY_STEPS-1-g];
            ua_reg[g]   <= mu_reg[g];
        end
    end

    logic [ACC_W-1:0]       fmag;
    logic [TP_W-1:0]        fr;

    always_comb
    begin
        fmag = acc_reg[POLY_STEPS-1][ACC_W-1] ? ACC_W'(-acc_reg[POLY_STEPS-1])
                                               : ACC_W'(acc_reg[POLY_STEPS-1]);
        fr   = TP_W'((fmag + ACC_W'(64'd1 << (FIN_SH - 1))) >> FIN_SH);
    end

    always_ff @(posedge clk)
    begin
        tp_reg <= acc_reg[POLY_STEPS-1][ACC_W-1] ? -$signed(fr) : $signed(fr);
    end

    // branch select and clipping
    rtd_quad_t               qx;
    logic signed [31:0]      tpi;
    logic signed [31:0]      t_next;
    logic                    sat_next;
    logic                    poly_next;
    logic                    done_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic                    sat_reg;
    logic                    poly_reg;

    always_comb
    begin
        qx        = qd_reg[QDLY-1];
        tpi       = 32'(tp_reg);
        t_next    = TEMP_MAX_I;
        sat_next  = 1'b0;
        poly_next = 1'b0;
        if (qx.sat)
            sat_next = 1'b1;
        else if (qx.quad)
        begin
            if (64'(qx.tq) > TEMP_MAX_U)
                sat_next = 1'b1;
            else
                t_next = 32'(qx.tq);
        end
        else
        begin
            poly_next = 1'b1;
            if (tpi > TEMP_MAX_I)
                sat_next = 1'b1;
            else if (tpi < TEMP_MIN_I)
            begin
                t_next   = TEMP_MIN_I;
                sat_next = 1'b1;
            end
            else
                t_next = tpi;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= qx.valid;
    end

    always_ff @(posedge clk)
    begin
        temp_reg <= TEMP_W'(t_next);
        sat_reg  <= sat_next;
        poly_reg <= poly_next;
    end

    assign done            = done_reg;
    assign temperature     = temp_reg;
    assign saturated       = sat_reg;
    assign used_polynomial = poly_reg;

endmodule

/* bench/tb_rtd_code_to_temperature.sv */
`timescale 1ns / 1ps
module tb_rtd_code_to_temperature;
    import rtd_pkg::*;

    // clock, reset and block ports
    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [CODE_W-1:0]        rtd_code;
    logic                     cfg_write;
    logic [0:0]               cfg_index;
    logic [CFG_W-1:0]         cfg_data;
    logic                     done;
    logic signed [TEMP_W-1:0] temperature;
    logic                     saturated;
    logic                     used_polynomial;

    rtd_code_to_temperature DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .rtd_code        (rtd_code),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .done            (done),
        .temperature     (temperature),
        .saturated       (saturated),
        .used_polynomial (used_polynomial)
    );

    // one predicted reading
    typedef struct {
        logic [TEMP_W-1:0] temp;
        logic              sat;
        logic              poly;
    } reading_t;

    // fixed-point constants of the inverse quadratic and the fifth-order fit
    localparam longint unsigned DISC_A2_4B   = 64'd1758480889;
    localparam longint unsigned FOUR_B_MAG   = 64'd231000000;
    localparam longint unsigned A_Q16        = 64'd39083 * 64'd65536;
    localparam longint unsigned QUAD_DEN     = 64'd1155 * 64'd65536;
    localparam longint          CVD_MAX      = 262143;
    localparam longint          CVD_MIN      = -131072;
    localparam int              HOLDOFF      = 130;
    localparam int              STALL_LIMIT  = 2000;

    longint fit_coef [6] = '{
        -64'sd4060421816, 64'sd4773426653, 64'sd710806780,
        -64'sd169799780, -64'sd126924948, 64'sd87869912
    };

    // model copy of the two registers
    logic [CFG_W-1:0] nominal_ohms;
    logic [CFG_W-1:0] ref_ohms;

    reading_t pending_readings [$];
    int       error_count;
    int       items_sent;
    int       readings_checked;
    int       poly_seen;
    int       sat_seen;
    int       idle_cycles;

    // floor integer square root, bit by bit
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // a * m / 2^sh rounded half away from zero
    function automatic longint mul_shift_round(longint a, longint unsigned m, int sh);
        longint unsigned mag;
        longint unsigned p;
        mag = (a < 0) ? longint'(-a) : a;
        p = (mag * m + (64'd1 << (sh - 1))) >> sh;
        return (a < 0) ? -longint'(p) : longint'(p);
    endfunction

    // code to temperature under the current register values
    function automatic reading_t code_to_temp(logic [CODE_W-1:0] code);
        reading_t        res;
        longint unsigned r0, rq, lim, p, q, rem, term, s, n, u;
        longint          t, acc;
        logic            sat;
        logic            poly;
        r0   = (nominal_ohms == 0) ? 1 : nominal_ohms;
        rq   = longint'(code) * longint'(ref_ohms) * 2;
        lim  = DISC_A2_4B << 32;
        p    = FOUR_B_MAG * rq;
        q    = p / r0;
        rem  = p % r0;
        sat  = 1'b0;
        poly = 1'b0;
        t    = 0;
        if (q > (DISC_A2_4B << 16))
        begin
            t = CVD_MAX;
            sat = 1'b1;
        end
        else
        begin
            term = (q << 16) + ((rem << 16) / r0);
            if (term > lim)
            begin
                // discriminant below zero: past the top of the quadratic
                t = CVD_MAX;
                sat = 1'b1;
            end
            else
            begin
                s = int_sqrt(lim - term);
                if (s <= A_Q16)
                begin
                    n = A_Q16 - s;
                    t = longint'((((n * 100) << TEMP_FRAC_BITS) + QUAD_DEN / 2) / QUAD_DEN);
                end
                else
                begin
                    // negative range: horner in Rn/128
                    u = (rq * 200) / r0;
                    if (u > (64'd1 << 24))
                        u = 64'd1 << 24;
                    acc = fit_coef[5];
                    for (int k = 4; k >= 0; k--)
                        acc = mul_shift_round(acc, u, 24) + fit_coef[k];
                    t = mul_shift_round(acc, 1, 24 - TEMP_FRAC_BITS);
                    poly = 1'b1;
                end
            end
        end
        if (t > CVD_MAX)
        begin
            t = CVD_MAX;
            sat = 1'b1;
        end
        else if (t < CVD_MIN)
        begin
            t = CVD_MIN;
            sat = 1'b1;
        end
        res.temp = t[TEMP_W-1:0];
        res.sat  = sat;
        res.poly = poly;
        return res;
    endfunction

    // 8 ns clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // compare each done pulse with the oldest prediction
    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && done)
        begin
            if (pending_readings.size() == 0)
            begin
                $error("unexpected reading: temperature %0d", temperature);
                error_count++;
            end
            else
            begin
                want = pending_readings.pop_front();
                readings_checked++;
                if (want.poly)
                    poly_seen++;
                if (want.sat)
                    sat_seen++;
                if (temperature !== want.temp)
                begin
                    $error("temperature: expected %0d, got %0d",
                           $signed(want.temp), temperature);
                    error_count++;
                end
                if (saturated !== want.sat)
                begin
                    $error("saturated: expected %0b, got %0b", want.sat, saturated);
                    error_count++;
                end
                if (used_polynomial !== want.poly)
                begin
                    $error("used_polynomial: expected %0b, got %0b",
                           want.poly, used_polynomial);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no item accepted and no reading out
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[rtd_code_to_temperature] ERROR");
            $finish;
        end
    end

    // register write; block must be idle
    task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_NOMINAL)
            nominal_ohms = value;
        else
            ref_ohms = value;
    endtask

    task automatic set_sensor(logic [CFG_W-1:0] r0, logic [CFG_W-1:0] rref);
        write_reg(CFG_NOMINAL, r0);
        write_reg(CFG_REFERENCE, rref);
    endtask

    // send one code after a gap; start stays high across back-to-back items
    task automatic send_code(logic [CODE_W-1:0] code, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        rtd_code <= code;
        do
            @(posedge clk);
        while (busy);
        pending_readings.push_back(code_to_temp(code));
        items_sent++;
    endtask

    // random gap, with runs of back-to-back items
    function automatic int pick_gap(bit burst);
        return burst ? 0 : $urandom_range(0, 12);
    endfunction

    // wait for every pending reading, then the pipeline depth
    task automatic drain;
        start <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (HOLDOFF) @(posedge clk);
    endtask

    // code for a given resistance in ohms under the current reference
    function automatic logic [CODE_W-1:0] code_for(longint ohms);
        longint c;
        c = (ref_ohms == 0) ? 0 : (ohms * 32768) / ref_ohms;
        if (c > 32767)
            c = 32767;
        if (c < 0)
            c = 0;
        return c[CODE_W-1:0];
    endfunction

    // extremes of the code, the zero-degree point and both branches
    task automatic test_directed;
        send_code('0, 0);
        send_code('1, 0);
        send_code(15'h7FFF, 3);
        send_code(15'h5555, 0);
        send_code(15'h2AAA, 1);
        send_code(code_for(100), 0);
        send_code(code_for(99), 0);
        send_code(code_for(101), 2);
        send_code(code_for(18), 0);
        send_code(code_for(60), 0);
        send_code(code_for(138), 0);
        send_code(code_for(390), 5);
        send_code(15'h4000, 0);
        drain();
    endtask

    // register extremes, zero nominal and zero reference included
    task automatic test_register_extremes;
        set_sensor(16'd1, 16'd65535);
        send_code(15'h7FFF, 0);
        send_code(15'h0001, 0);
        send_code('0, 0);
        drain();
        set_sensor(16'd65535, 16'd1);
        send_code(15'h7FFF, 0);
        send_code(15'h0001, 1);
        drain();
        set_sensor(16'd0, 16'd430);
        send_code(15'h0010, 0);
        send_code(15'h7FFF, 0);
        drain();
        set_sensor(16'd100, 16'd0);
        send_code(15'h7FFF, 0);
        send_code(15'h1234, 2);
        drain();
        set_sensor(16'd65535, 16'd65535);
        send_code(15'h7FFF, 0);
        send_code(15'h6000, 0);
        drain();
    endtask

    // random codes; mostly within the sensor's span, some anywhere
    task automatic test_random(logic [CFG_W-1:0] r0, logic [CFG_W-1:0] rref, int count);
        bit burst;
        longint ohms;
        set_sensor(r0, rref);
        burst = 1'b0;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                burst = ~burst;
            if ($urandom_range(0, 3) != 0 && r0 != 0)
            begin
                ohms = $urandom_range(32'(r0) / 6, 32'(r0) * 4 + 1);
                send_code(code_for(ohms) ^ CODE_W'($urandom_range(0, 3)), pick_gap(burst));
            end
            else
                send_code(CODE_W'($urandom_range(0, 32767)), pick_gap(burst));
        end
        drain();
    endtask

    initial
    begin
        rst_n            = 1'b0;
        start            = 1'b0;
        rtd_code         = '0;
        cfg_write        = 1'b0;
        cfg_index        = CFG_NOMINAL;
        cfg_data         = '0;
        nominal_ohms     = 16'd100;
        ref_ohms         = 16'd430;
        error_count      = 0;
        items_sent       = 0;
        readings_checked = 0;
        poly_seen        = 0;
        sat_seen         = 0;
        idle_cycles      = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_register_extremes();
        test_random(16'd100, 16'd430, 200);
        test_random(16'd1000, 16'd4300, 200);
        test_random(16'd100, 16'd400, 150);
        test_random(CFG_W'($urandom_range(1, 65535)), CFG_W'($urandom_range(1, 65535)), 120);
        test_random(16'd1, 16'd65535, 60);
        test_random(16'd65535, 16'd1, 60);
        test_random(16'd100, 16'd430, 80);

        $display("covered %0d codes, %0d readings (%0d polynomial, %0d clipped)",
                 items_sent, readings_checked, poly_seen, sat_seen);
        $display("across default, 1k-ohm, zero and extreme register settings");
        if (error_count == 0 && pending_readings.size() == 0)
            $display("[rtd_code_to_temperature] OK");
        else
            $display("[rtd_code_to_temperature] ERROR");
        $finish;
    end

endmodule
